### rtl/assert_macros.svh
// assertion helpers used by the allocator core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define SCBA_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("scba assertion failed");

// implication checked on every rising clock edge outside reset
`define SCBA_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("scba implication failed");

`endif

### rtl/scba_pkg.sv
package scba_pkg;
    localparam int ADDR_W     = 32;
    localparam int SIZE_W     = 13;
    localparam int PAGE_LOG2  = 12;
    localparam int MIN_LG     = 3;
    localparam int MAX_LG     = 11;
    localparam int NCLASS     = MAX_LG - MIN_LG + 1;
    localparam int SLOT_W     = PAGE_LOG2 - MIN_LG;
    localparam int MAX_PAGES  = 64;
    localparam int PAGE_W     = 6;
    localparam int ID_W       = PAGE_W + SLOT_W;
    localparam int CLS_W      = 4;
    localparam int FB_W       = SLOT_W + 1;
    localparam int CNT_W      = ID_W + 1;
    localparam int FQC_W      = PAGE_W + 1;
    localparam int RP_W       = 7;
    localparam int PR_W       = CLS_W + FB_W;

    // result status codes
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_OOM = 2'd1;
    localparam logic [1:0] ST_INV = 2'd2;

    // operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // configuration register indexes
    localparam logic CFG_BASE  = 1'b0;
    localparam logic CFG_PAGES = 1'b1;

    // smallest class whose block holds size bytes, else the largest class
    function automatic logic [CLS_W-1:0] cls_of(input logic [SIZE_W-1:0] size);
        logic [CLS_W-1:0] r;
        r = CLS_W'(NCLASS - 1);
        for (int i = NCLASS - 1; i >= 0; i--) begin
            if ((14'd1 << (i + MIN_LG)) >= {1'b0, size}) begin
                r = CLS_W'(i);
            end
        end
        return r;
    endfunction
endpackage

### rtl/scba_ram.sv
module scba_ram #(
    parameter int ADDR_W = 6,
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);
    logic [DATA_W-1:0] r_mem [2**ADDR_W];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### rtl/scba_alu.sv
module scba_alu (
    input  logic [scba_pkg::ADDR_W-1:0] i_a,
    input  logic [scba_pkg::ADDR_W-1:0] i_b,
    input  logic                        i_sub,
    output logic [scba_pkg::ADDR_W-1:0] o_res
);
    import scba_pkg::*;

    // shared address adder: grant address or offset into the region
    assign o_res = i_sub ? (i_a - i_b) : (i_a + i_b);
endmodule

### rtl/size_class_block_allocator_core.sv
// Slab allocator over up to 64 pages of 4096 bytes with nine power-of-two
// classes (8 to 2048 bytes). One request is in work at a time; o_in_ready is
// high only while the sequencer is idle. An allocate is served from its class
// list, else by splitting a page from the free page queue, else from the next
// larger class that holds a block. A free that returns its page unlinks every
// block of the page first, and each unlink waits for a registered read of the
// link memories. A configuration write is taken only while the sequencer is
// idle, and the region_pages write reinitializes all lists at once.
module size_class_block_allocator_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_operation,
    input  logic [scba_pkg::SIZE_W-1:0] i_request_size,
    input  logic [scba_pkg::ADDR_W-1:0] i_block_address,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [scba_pkg::ADDR_W-1:0] o_granted_address,
    output logic [1:0]                  o_status,
    output logic                        o_page_taken,
    output logic                        o_page_returned,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic                        i_cfg_index,
    input  logic [scba_pkg::ADDR_W-1:0] i_cfg_data
);
    import scba_pkg::*;

    `include "assert_macros.svh"

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DEC  = 4'd1;
    localparam logic [3:0] S_SCAN = 4'd2;
    localparam logic [3:0] S_SPL0 = 4'd3;
    localparam logic [3:0] S_SPL1 = 4'd4;
    localparam logic [3:0] S_SPLP = 4'd5;
    localparam logic [3:0] S_TK0  = 4'd6;
    localparam logic [3:0] S_TK1  = 4'd7;
    localparam logic [3:0] S_F0   = 4'd8;
    localparam logic [3:0] S_F1   = 4'd9;
    localparam logic [3:0] S_F2   = 4'd10;
    localparam logic [3:0] S_RL0  = 4'd11;
    localparam logic [3:0] S_RL1  = 4'd12;
    localparam logic [3:0] S_RLE  = 4'd13;
    localparam logic [3:0] S_DONE = 4'd14;

    logic [3:0]        r_state;
    logic [ADDR_W-1:0] r_base;
    logic [RP_W-1:0]   r_pages;
    logic [SIZE_W-1:0] r_size;
    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] r_off;
    logic [CLS_W-1:0]  r_cls;
    logic [ID_W-1:0]   r_id;
    logic [PAGE_W-1:0] r_page;
    logic [FB_W-1:0]   r_k;
    logic [FB_W-1:0]   r_fb;
    logic [1:0]        r_st;
    logic              r_taken;
    logic              r_ret;
    logic [ADDR_W-1:0] r_ga;
    logic              r_ovalid;

    logic [ID_W-1:0]   r_head [NCLASS];
    logic [ID_W-1:0]   r_tail [NCLASS];
    logic [CNT_W-1:0]  r_cnt  [NCLASS];
    logic [PAGE_W-1:0] r_fq_head;
    logic [FQC_W-1:0]  r_fq_count;
    logic              r_fq_vld [MAX_PAGES];
    logic              r_pr_vld [MAX_PAGES];
    logic              r_fqv_q;
    logic              r_prv_q;

    // memory ports
    logic              nx_we, pv_we, fr_we, pr_we, fq_we;
    logic [ID_W-1:0]   nx_waddr, nx_wdata, nx_raddr, nx_rdata;
    logic [ID_W-1:0]   pv_waddr, pv_wdata, pv_raddr, pv_rdata;
    logic [ID_W-1:0]   fr_waddr, fr_raddr;
    logic              fr_wdata, fr_rdata;
    logic [PAGE_W-1:0] pr_waddr, pr_raddr, fq_waddr, fq_raddr, fq_wdata, fq_rdata;
    logic [PR_W-1:0]   pr_wdata, pr_rdata;

    // derived values
    logic [ID_W-1:0]   head_c, tail_c, blk, pid, uid;
    logic [CNT_W-1:0]  cnt_c;
    logic [FB_W-1:0]   bpp_c, fb1;
    logic [17:0]       kshift;
    logic [PR_W-1:0]   prd;
    logic [CLS_W-1:0]  pr_code, f_c, dec_cls;
    logic [FB_W-1:0]   pr_fb;
    logic [11:0]       f_within, f_mask;
    logic [ID_W-1:0]   f_id;
    logic [PAGE_W-1:0] sp_page;
    logic [RP_W-1:0]   active;
    logic [ADDR_W-1:0] alu_a, alu_b, alu_res;
    logic              alu_sub;
    logic              do_push, do_unlink, mid_unlink;

    assign head_c   = r_head[r_cls];
    assign tail_c   = r_tail[r_cls];
    assign cnt_c    = r_cnt[r_cls];
    assign bpp_c    = FB_W'((1 << SLOT_W) >> r_cls);
    assign fb1      = r_fb + FB_W'(1);
    assign kshift   = 18'(r_k) << r_cls;
    assign blk      = {r_page, kshift[SLOT_W-1:0]};
    assign prd      = r_prv_q ? pr_rdata : '0;
    assign pr_code  = prd[PR_W-1:FB_W];
    assign pr_fb    = prd[FB_W-1:0];
    assign f_c      = pr_code - CLS_W'(1);
    assign f_within = r_off[11:0];
    assign f_mask   = 12'((13'd8 << f_c) - 13'd1);
    assign f_id     = {r_off[17:12], f_within[11:MIN_LG]};
    assign sp_page  = r_fqv_q ? fq_rdata : r_fq_head;
    assign active   = (r_pages > RP_W'(MAX_PAGES)) ? RP_W'(MAX_PAGES) : r_pages;
    assign dec_cls  = cls_of(r_size);
    assign pid      = (r_state == S_SPLP) ? blk : r_id;
    assign uid      = (r_state == S_TK1) ? head_c : blk;
    assign do_push  = (r_state == S_SPLP) || (r_state == S_F2 && !fr_rdata);
    assign do_unlink = (r_state == S_TK1) || (r_state == S_RL1);
    assign mid_unlink = do_unlink && (cnt_c > CNT_W'(1)) && (uid != head_c)
                        && (uid != tail_c);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;

    // shared adder operands
    always_comb begin
        alu_sub = (r_state == S_F0);
        alu_a   = alu_sub ? r_addr : r_base;
        alu_b   = alu_sub ? r_base : {{(ADDR_W-ID_W-MIN_LG){1'b0}}, head_c, 3'b000};
    end

    scba_alu u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_sub (alu_sub),
        .o_res (alu_res)
    );

    // memory port control
    always_comb begin
        nx_we = 1'b0; nx_waddr = '0; nx_wdata = '0; nx_raddr = blk;
        pv_we = 1'b0; pv_waddr = '0; pv_wdata = '0; pv_raddr = blk;
        fr_we = 1'b0; fr_waddr = '0; fr_wdata = 1'b0; fr_raddr = f_id;
        pr_we = 1'b0; pr_waddr = '0; pr_wdata = '0; pr_raddr = head_c[ID_W-1:SLOT_W];
        fq_we = 1'b0; fq_waddr = '0; fq_wdata = '0; fq_raddr = r_fq_head;
        if (r_state == S_TK0) begin
            nx_raddr = head_c;
        end
        if (r_state == S_F0) begin
            pr_raddr = alu_res[17:12];
        end
        if (do_push) begin
            fr_we = 1'b1; fr_waddr = pid; fr_wdata = 1'b1;
            if (cnt_c != '0) begin
                nx_we = 1'b1; nx_waddr = tail_c; nx_wdata = pid;
                pv_we = 1'b1; pv_waddr = pid; pv_wdata = tail_c;
            end
        end
        if (do_unlink) begin
            fr_we = 1'b1; fr_waddr = uid; fr_wdata = 1'b0;
        end
        if (mid_unlink) begin
            nx_we = 1'b1; nx_waddr = pv_rdata; nx_wdata = nx_rdata;
            pv_we = 1'b1; pv_waddr = nx_rdata; pv_wdata = pv_rdata;
        end
        case (r_state)
            S_SPL1: begin
                pr_we = 1'b1; pr_waddr = sp_page;
                pr_wdata = {r_cls + CLS_W'(1), bpp_c};
            end
            S_TK1: begin
                pr_we = 1'b1; pr_waddr = head_c[ID_W-1:SLOT_W];
                pr_wdata = {pr_code, pr_fb - FB_W'(1)};
            end
            S_F2: begin
                if (!fr_rdata && fb1 != bpp_c) begin
                    pr_we = 1'b1; pr_waddr = r_page;
                    pr_wdata = {r_cls + CLS_W'(1), fb1};
                end
            end
            S_RLE: begin
                pr_we = 1'b1; pr_waddr = r_page; pr_wdata = '0;
                fq_we = 1'b1; fq_wdata = r_page;
                fq_waddr = PAGE_W'(FQC_W'(r_fq_head) + r_fq_count);
            end
            default: begin
            end
        endcase
    end

    scba_ram #(.ADDR_W(ID_W), .DATA_W(ID_W)) u_next (
        .i_clk(i_clk), .i_we(nx_we), .i_waddr(nx_waddr), .i_wdata(nx_wdata),
        .i_raddr(nx_raddr), .o_rdata(nx_rdata)
    );

    scba_ram #(.ADDR_W(ID_W), .DATA_W(ID_W)) u_prev (
        .i_clk(i_clk), .i_we(pv_we), .i_waddr(pv_waddr), .i_wdata(pv_wdata),
        .i_raddr(pv_raddr), .o_rdata(pv_rdata)
    );

    scba_ram #(.ADDR_W(ID_W), .DATA_W(1)) u_free (
        .i_clk(i_clk), .i_we(fr_we), .i_waddr(fr_waddr), .i_wdata(fr_wdata),
        .i_raddr(fr_raddr), .o_rdata(fr_rdata)
    );

    scba_ram #(.ADDR_W(PAGE_W), .DATA_W(PR_W)) u_page (
        .i_clk(i_clk), .i_we(pr_we), .i_waddr(pr_waddr), .i_wdata(pr_wdata),
        .i_raddr(pr_raddr), .o_rdata(pr_rdata)
    );

    scba_ram #(.ADDR_W(PAGE_W), .DATA_W(PAGE_W)) u_fq (
        .i_clk(i_clk), .i_we(fq_we), .i_waddr(fq_waddr), .i_wdata(fq_wdata),
        .i_raddr(fq_raddr), .o_rdata(fq_rdata)
    );

    // valid bits read alongside the page and queue memories
    always_ff @(posedge i_clk) begin
        r_fqv_q <= r_fq_vld[fq_raddr];
        r_prv_q <= r_pr_vld[pr_raddr];
    end

    // sequencer, list heads and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ovalid   <= 1'b0;
            r_base     <= '0;
            r_pages    <= RP_W'(MAX_PAGES);
            r_fq_head  <= '0;
            r_fq_count <= FQC_W'(MAX_PAGES);
            for (int i = 0; i < NCLASS; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
                r_cnt[i]  <= '0;
            end
            for (int i = 0; i < MAX_PAGES; i++) begin
                r_fq_vld[i] <= 1'b0;
                r_pr_vld[i] <= 1'b0;
            end
        end else begin
            if (fq_we) begin
                r_fq_vld[fq_waddr] <= 1'b1;
            end
            if (pr_we) begin
                r_pr_vld[pr_waddr] <= 1'b1;
            end
            if (r_ovalid && i_out_ready && r_state != S_DONE) begin
                r_ovalid <= 1'b0;
            end

            // list updates
            if (do_push) begin
                if (cnt_c == '0) begin
                    r_head[r_cls] <= pid;
                end
                r_tail[r_cls] <= pid;
                r_cnt[r_cls]  <= cnt_c + CNT_W'(1);
            end
            if (do_unlink && cnt_c != '0) begin
                if (cnt_c == CNT_W'(1)) begin
                    r_cnt[r_cls] <= '0;
                end else begin
                    if (uid == head_c) begin
                        r_head[r_cls] <= nx_rdata;
                    end else if (uid == tail_c) begin
                        r_tail[r_cls] <= pv_rdata;
                    end
                    r_cnt[r_cls] <= cnt_c - CNT_W'(1);
                end
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_size  <= i_request_size;
                        r_addr  <= i_block_address;
                        r_st    <= ST_OK;
                        r_taken <= 1'b0;
                        r_ret   <= 1'b0;
                        r_ga    <= '0;
                        r_state <= (i_operation == OP_FREE) ? S_F0 : S_DEC;
                    end
                end
                S_DEC: begin
                    r_cls <= dec_cls;
                    if (r_size > SIZE_W'(1 << MAX_LG)) begin
                        r_st    <= ST_INV;
                        r_state <= S_DONE;
                    end else if (r_cnt[dec_cls] != '0) begin
                        r_state <= S_TK0;
                    end else if (r_fq_count != '0) begin
                        r_state <= S_SPL0;
                    end else if (dec_cls == CLS_W'(NCLASS - 1)) begin
                        r_st    <= ST_OOM;
                        r_state <= S_DONE;
                    end else begin
                        r_cls   <= dec_cls + CLS_W'(1);
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (cnt_c != '0) begin
                        r_state <= S_TK0;
                    end else if (r_cls == CLS_W'(NCLASS - 1)) begin
                        r_st    <= ST_OOM;
                        r_state <= S_DONE;
                    end else begin
                        r_cls <= r_cls + CLS_W'(1);
                    end
                end
                S_SPL0: begin
                    r_state <= S_SPL1;
                end
                S_SPL1: begin
                    r_page     <= sp_page;
                    r_fq_head  <= r_fq_head + PAGE_W'(1);
                    r_fq_count <= r_fq_count - FQC_W'(1);
                    r_k        <= '0;
                    r_taken    <= 1'b1;
                    r_state    <= S_SPLP;
                end
                S_SPLP: begin
                    r_k <= r_k + FB_W'(1);
                    if (r_k == bpp_c - FB_W'(1)) begin
                        r_state <= S_TK0;
                    end
                end
                S_TK0: begin
                    r_state <= S_TK1;
                end
                S_TK1: begin
                    r_ga    <= alu_res;
                    r_state <= S_DONE;
                end
                S_F0: begin
                    r_off <= alu_res;
                    if (alu_res[ADDR_W-1:PAGE_LOG2] >= (ADDR_W-PAGE_LOG2)'(active)) begin
                        r_st    <= ST_INV;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_F1;
                    end
                end
                S_F1: begin
                    if (pr_code == '0 || (f_within & f_mask) != '0) begin
                        r_st    <= ST_INV;
                        r_state <= S_DONE;
                    end else begin
                        r_cls   <= f_c;
                        r_id    <= f_id;
                        r_page  <= r_off[17:12];
                        r_fb    <= pr_fb;
                        r_state <= S_F2;
                    end
                end
                S_F2: begin
                    if (fr_rdata) begin
                        r_st    <= ST_INV;
                        r_state <= S_DONE;
                    end else if (fb1 == bpp_c) begin
                        r_k     <= '0;
                        r_state <= S_RL0;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_RL0: begin
                    r_state <= S_RL1;
                end
                S_RL1: begin
                    r_k     <= r_k + FB_W'(1);
                    r_state <= (r_k == bpp_c - FB_W'(1)) ? S_RLE : S_RL0;
                end
                S_RLE: begin
                    r_fq_count <= r_fq_count + FQC_W'(1);
                    r_ret      <= 1'b1;
                    r_state    <= S_DONE;
                end
                S_DONE: begin
                    if (!r_ovalid || i_out_ready) begin
                        o_granted_address <= (r_st == ST_OK) ? r_ga : '0;
                        o_status          <= r_st;
                        o_page_taken      <= r_taken;
                        o_page_returned   <= r_ret;
                        r_ovalid          <= 1'b1;
                        r_state           <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // configuration beat
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_BASE) begin
                    r_base <= i_cfg_data;
                end else begin
                    r_pages    <= i_cfg_data[RP_W-1:0];
                    r_fq_head  <= '0;
                    r_fq_count <= (i_cfg_data[RP_W-1:0] > RP_W'(MAX_PAGES)) ?
                                  FQC_W'(MAX_PAGES) : FQC_W'(i_cfg_data[RP_W-1:0]);
                    for (int i = 0; i < NCLASS; i++) begin
                        r_head[i] <= '0;
                        r_tail[i] <= '0;
                        r_cnt[i]  <= '0;
                    end
                    for (int i = 0; i < MAX_PAGES; i++) begin
                        r_fq_vld[i] <= 1'b0;
                        r_pr_vld[i] <= 1'b0;
                    end
                end
            end
        end
    end

    `SCBA_ASSERT(a_fq_bound, r_fq_count <= FQC_W'(MAX_PAGES))
    `SCBA_IMPLY(a_ga_zero, o_out_valid && o_status != ST_OK, o_granted_address == '0)
    `SCBA_IMPLY(a_taken_ok, o_out_valid && o_page_taken, o_status == ST_OK && !o_page_returned)
    `SCBA_IMPLY(a_split_range, r_state == S_SPLP, r_k < bpp_c)
endmodule

### dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import scba_pkg::*;

    localparam int HALF_PERIOD = 10;
    localparam int SLOTS_PG    = 1 << SLOT_W;
    localparam int NSLOT       = MAX_PAGES * SLOTS_PG;
    localparam int DRAIN_WAIT  = 1200;
    localparam longint CYCLE_LIMIT = 6000000;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [1:0]        st;
        logic              tk;
        logic              rt;
    } t_alloc_result;

    typedef struct {
        logic              op;
        logic [SIZE_W-1:0] sz;
        logic [ADDR_W-1:0] ad;
        bit                pin;
        t_alloc_result     res;
    } t_stim_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    logic                i_operation = OP_ALLOC;
    logic [SIZE_W-1:0]   i_request_size = '0;
    logic [ADDR_W-1:0]   i_block_address = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic [ADDR_W-1:0]   o_granted_address;
    logic [1:0]          o_status;
    logic                o_page_taken;
    logic                o_page_returned;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic                i_cfg_index = CFG_BASE;
    logic [ADDR_W-1:0]   i_cfg_data = '0;

    size_class_block_allocator_core dut (.*);

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // allocator mirror state
    logic [ADDR_W-1:0] mir_base;
    logic [RP_W-1:0]   mir_pages;
    logic [CLS_W-1:0]  pg_cls [MAX_PAGES];
    int unsigned       pg_free [MAX_PAGES];
    int unsigned       fpq [MAX_PAGES];
    int unsigned       fpq_head, fpq_cnt;
    int unsigned       nxt_link [NSLOT];
    int unsigned       prv_link [NSLOT];
    bit                slot_free [NSLOT];
    int unsigned       cls_head [NCLASS], cls_tail [NCLASS], cls_cnt [NCLASS];

    t_alloc_result     expected_q [$];
    logic [ADDR_W-1:0] live_blocks [$];
    int                mismatches = 0;
    int                beats_sent = 0, beats_seen = 0;
    int                n_alloc = 0, n_free = 0, n_oom = 0, n_inv = 0, n_take = 0, n_ret = 0;
    longint            cycles = 0;

    function automatic int unsigned active_pages();
        return (mir_pages > MAX_PAGES) ? MAX_PAGES : mir_pages;
    endfunction

    function automatic void reinit_lists();
        for (int i = 0; i < MAX_PAGES; i++) begin
            pg_cls[i] = '0;
            pg_free[i] = 0;
            fpq[i] = i;
        end
        for (int i = 0; i < NSLOT; i++) slot_free[i] = 1'b0;
        for (int c = 0; c < NCLASS; c++) begin
            cls_head[c] = 0;
            cls_tail[c] = 0;
            cls_cnt[c] = 0;
        end
        fpq_head = 0;
        fpq_cnt = active_pages();
    endfunction

    function automatic void class_push(int unsigned c, int unsigned id);
        if (cls_cnt[c] == 0) begin
            cls_head[c] = id;
        end else begin
            nxt_link[cls_tail[c]] = id;
            prv_link[id] = cls_tail[c];
        end
        cls_tail[c] = id;
        cls_cnt[c]++;
    endfunction

    function automatic void class_unlink(int unsigned c, int unsigned id);
        if (cls_cnt[c] == 0) return;
        if (cls_cnt[c] == 1) begin
            cls_cnt[c] = 0;
            return;
        end
        if (id == cls_head[c]) begin
            cls_head[c] = nxt_link[id];
        end else if (id == cls_tail[c]) begin
            cls_tail[c] = prv_link[id];
        end else begin
            nxt_link[prv_link[id]] = nxt_link[id];
            prv_link[nxt_link[id]] = prv_link[id];
        end
        cls_cnt[c]--;
    endfunction

    function automatic logic [ADDR_W-1:0] grab_block(int unsigned c);
        int unsigned id, pg, slot;
        id = cls_head[c];
        pg = id / SLOTS_PG;
        slot = id % SLOTS_PG;
        class_unlink(c, id);
        slot_free[id] = 1'b0;
        pg_free[pg]--;
        return mir_base + ADDR_W'(pg << PAGE_LOG2) + ADDR_W'(slot << MIN_LG);
    endfunction

    // next result of the allocator for one request, updating the mirror
    function automatic t_alloc_result slab_predict(logic op, logic [SIZE_W-1:0] sz,
                                                    logic [ADDR_W-1:0] ad);
        t_alloc_result r;
        int unsigned idx, bpp, pg, c, lg, id, in_page;
        logic [ADDR_W-1:0] off;
        r = '{addr: '0, st: ST_OK, tk: 1'b0, rt: 1'b0};
        if (op == OP_ALLOC) begin
            idx = 0;
            while (idx < NCLASS - 1 && (1 << (idx + MIN_LG)) < sz) idx++;
            bpp = (1 << PAGE_LOG2) >> (idx + MIN_LG);
            if (sz > (1 << MAX_LG)) begin
                r.st = ST_INV;
            end else if (cls_cnt[idx] > 0) begin
                r.addr = grab_block(idx);
            end else if (fpq_cnt > 0) begin
                pg = fpq[fpq_head] % MAX_PAGES;
                fpq_head = (fpq_head + 1) % MAX_PAGES;
                fpq_cnt--;
                pg_cls[pg] = CLS_W'(idx + 1);
                pg_free[pg] = bpp;
                for (int k = 0; k < bpp; k++) begin
                    id = pg * SLOTS_PG + k * (1 << idx);
                    slot_free[id] = 1'b1;
                    class_push(idx, id);
                end
                r.tk = 1'b1;
                r.addr = grab_block(idx);
            end else begin
                r.st = ST_OOM;
                for (c = idx + 1; c < NCLASS; c++) begin
                    if (cls_cnt[c] > 0) begin
                        r.addr = grab_block(c);
                        r.st = ST_OK;
                        break;
                    end
                end
            end
        end else begin
            off = ad - mir_base;
            pg = off >> PAGE_LOG2;
            in_page = off[PAGE_LOG2-1:0];
            if (pg >= active_pages() || pg_cls[pg] == 0) begin
                r.st = ST_INV;
            end else begin
                c = pg_cls[pg] - 1;
                lg = c + MIN_LG;
                id = pg * SLOTS_PG + (in_page >> MIN_LG);
                if ((in_page & ((1 << lg) - 1)) != 0 || slot_free[id]) begin
                    r.st = ST_INV;
                end else begin
                    slot_free[id] = 1'b1;
                    class_push(c, id);
                    pg_free[pg]++;
                    if (pg_free[pg] == ((1 << PAGE_LOG2) >> lg)) begin
                        // whole page free again: drop its blocks, requeue the page
                        for (int k = 0; k < pg_free[pg]; k++) begin
                            class_unlink(c, pg * SLOTS_PG + k * (1 << c));
                            slot_free[pg * SLOTS_PG + k * (1 << c)] = 1'b0;
                        end
                        pg_cls[pg] = '0;
                        pg_free[pg] = 0;
                        fpq[(fpq_head + fpq_cnt) % MAX_PAGES] = pg;
                        fpq_cnt++;
                        r.rt = 1'b1;
                    end
                end
            end
        end
        if (r.st != ST_OK) r.addr = '0;
        return r;
    endfunction

    // offer one request beat and record what it should produce
    task automatic send_req(input logic op, input logic [SIZE_W-1:0] sz,
                            input logic [ADDR_W-1:0] ad, input bit pin,
                            input t_alloc_result pinned, output t_alloc_result got);
        int gap;
        i_in_valid <= 1'b1;
        i_operation <= op;
        i_request_size <= sz;
        i_block_address <= ad;
        do @(posedge i_clk); while (!o_in_ready);
        got = slab_predict(op, sz, ad);
        expected_q.push_back(pin ? pinned : got);
        beats_sent++;
        if (op == OP_ALLOC) n_alloc++; else n_free++;
        if (got.st == ST_OOM) n_oom++;
        if (got.st == ST_INV) n_inv++;
        if (got.tk) n_take++;
        if (got.rt) n_ret++;
        if (op == OP_ALLOC && got.st == ST_OK) live_blocks.push_back(got.addr);
        gap = $urandom_range(0, 99);
        gap = (gap < 60) ? 0 : (gap < 90) ? $urandom_range(1, 3) : $urandom_range(10, 60);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // wait until the block has nothing left in flight
    task automatic settle();
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic idx, input logic [ADDR_W-1:0] val);
        logic [ADDR_W-1:0] delta;
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_BASE) begin
            // lists are kept, only the window moves
            delta = val - mir_base;
            foreach (live_blocks[i]) live_blocks[i] += delta;
            mir_base = val;
        end else begin
            mir_pages = val[RP_W-1:0];
            reinit_lists();
            live_blocks.delete();
        end
    endtask

    function automatic logic [SIZE_W-1:0] pick_size();
        int k, sel;
        sel = $urandom_range(0, 99);
        if (sel < 4) return '0;
        if (sel < 10) return SIZE_W'($urandom_range(2049, 8191));
        k = $urandom_range(0, NCLASS - 1);
        // small classes split costly pages, so favor larger ones
        if (k < 3 && $urandom_range(0, 1)) k = $urandom_range(3, NCLASS - 1);
        return SIZE_W'($urandom_range((k == 0) ? 1 : (1 << (k + MIN_LG - 1)) + 1,
                                      1 << (k + MIN_LG)));
    endfunction

    task automatic random_run(input int count);
        t_alloc_result got, none;
        logic [ADDR_W-1:0] a;
        int sel, j;
        none = '0;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 55 || live_blocks.size() == 0 && sel < 85) begin
                send_req(OP_ALLOC, pick_size(), ADDR_W'($urandom()), 1'b0, none, got);
            end else if (sel < 85) begin
                j = $urandom_range(0, live_blocks.size() - 1);
                a = live_blocks[j];
                live_blocks.delete(j);
                send_req(OP_FREE, SIZE_W'($urandom()), a, 1'b0, none, got);
            end else begin
                // likely invalid frees: wild, off by a few bytes, or near the window
                case ($urandom_range(0, 2))
                    0: a = $urandom();
                    1: a = (live_blocks.size() > 0) ? live_blocks[0] + $urandom_range(1, 7)
                                                    : mir_base + $urandom_range(0, 4095);
                    default: a = mir_base + ADDR_W'($urandom_range(0, 70) << PAGE_LOG2);
                endcase
                send_req(OP_FREE, SIZE_W'($urandom()), a, 1'b0, none, got);
            end
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_alloc_result want, seen;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            beats_seen++;
            seen = '{addr: o_granted_address, st: o_status, tk: o_page_taken,
                     rt: o_page_returned};
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %p", seen);
            end else begin
                want = expected_q.pop_front();
                if (seen !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: expected addr %h st %0d tk %0d rt %0d, got addr %h st %0d tk %0d rt %0d",
                                 beats_seen, want.addr, want.st, want.tk, want.rt,
                                 seen.addr, seen.st, seen.tk, seen.rt);
                end
            end
        end
    end

    // result side: random stalls plus one long hold so the block backs up
    initial begin
        int stall, burst;
        bit held;
        held = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (!held && beats_seen >= 400) begin
                held = 1'b1;
                i_out_ready <= 1'b0;
                repeat (600) @(posedge i_clk);
            end
            stall = $urandom_range(0, 99);
            stall = (stall < 50) ? 0 : (stall < 90) ? $urandom_range(1, 3)
                                                    : $urandom_range(10, 80);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            burst = $urandom_range(1, 40);
            repeat (burst) @(posedge i_clk);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic t_alloc_result res(logic [ADDR_W-1:0] a, logic [1:0] s,
                                          logic t, logic r);
        return '{addr: a, st: s, tk: t, rt: r};
    endfunction

    initial begin
        t_stim_row tab [$];
        t_alloc_result got;
        mir_base = '0;
        mir_pages = RP_W'(MAX_PAGES);
        reinit_lists();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows; pinned ones follow straight from the reset state
        tab.push_back('{OP_ALLOC, 13'd0,    32'h0,        1, res(32'h0, ST_OK, 1, 0)});
        tab.push_back('{OP_ALLOC, 13'd4096, 32'h0,        1, res(32'h0, ST_INV, 0, 0)});
        tab.push_back('{OP_ALLOC, 13'd2049, 32'h0,        1, res(32'h0, ST_INV, 0, 0)});
        tab.push_back('{OP_ALLOC, 13'h1FFF, 32'hFFFFFFFF, 1, res(32'h0, ST_INV, 0, 0)});
        tab.push_back('{OP_ALLOC, 13'd2048, 32'h0,        1, res(32'h1000, ST_OK, 1, 0)});
        tab.push_back('{OP_FREE,  13'h1FFF, 32'h1000,     1, res(32'h0, ST_OK, 0, 1)});
        tab.push_back('{OP_FREE,  13'd0,    32'h1000,     1, res(32'h0, ST_INV, 0, 0)});
        tab.push_back('{OP_FREE,  13'd0,    32'h4,        1, res(32'h0, ST_INV, 0, 0)});
        tab.push_back('{OP_FREE,  13'd0,    32'h8,        1, res(32'h0, ST_INV, 0, 0)});
        tab.push_back('{OP_FREE,  13'd0,    32'hFFFFFFF8, 1, res(32'h0, ST_INV, 0, 0)});
        tab.push_back('{OP_FREE,  13'd0,    32'h40000,    1, res(32'h0, ST_INV, 0, 0)});
        tab.push_back('{OP_FREE,  13'd0,    32'h0,        1, res(32'h0, ST_OK, 0, 1)});
        for (int k = 0; k < NCLASS; k++)
            tab.push_back('{OP_ALLOC, SIZE_W'((1 << (k + MIN_LG)) - 7), 32'h0, 0, '0});
        tab.push_back('{OP_ALLOC, 13'd2048, 32'h0, 0, '0});
        tab.push_back('{OP_ALLOC, 13'd8,    32'h0, 0, '0});
        foreach (tab[i]) begin
            if (tab[i].op == OP_FREE) begin
                foreach (live_blocks[j])
                    if (live_blocks[j] == tab[i].ad) begin
                        live_blocks.delete(j);
                        break;
                    end
            end
            send_req(tab[i].op, tab[i].sz, tab[i].ad, tab[i].pin, tab[i].res, got);
        end

        // random phases over several region settings
        random_run(260);
        cfg_write(CFG_BASE, 32'h8000_0000);
        random_run(60);
        cfg_write(CFG_PAGES, 32'd4);
        random_run(200);
        cfg_write(CFG_BASE, 32'hFFFF_E000);
        cfg_write(CFG_PAGES, 32'd2);
        random_run(160);
        cfg_write(CFG_PAGES, 32'd0);
        random_run(30);
        cfg_write(CFG_BASE, 32'hFFFF_FFFF);
        cfg_write(CFG_PAGES, 32'd1);
        random_run(120);
        cfg_write(CFG_BASE, 32'h0001_2000);
        cfg_write(CFG_PAGES, 32'd127);
        random_run(200);

        settle();
        $display("covered %0d requests: %0d allocates, %0d frees, %0d out of memory, %0d invalid",
                 beats_sent, n_alloc, n_free, n_oom, n_inv);
        $display("pages split %0d times and handed back %0d times", n_take, n_ret);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/scba_pkg.sv
rtl/scba_ram.sv
rtl/scba_alu.sv
rtl/size_class_block_allocator_core.sv
dv/testbench.sv
